>>> hdl/gdas_pkg.sv
package gdas_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned COUNT_W = 16;
    // day accumulator: day plus or minus a full count, signed
    localparam int unsigned ACC_W   = 17;
    // year modulo 400
    localparam int unsigned Y400_W  = 9;

    localparam logic [YEAR_W-1:0]  BASE_YEAR  = 14'd1900;
    localparam logic [Y400_W-1:0]  BASE_Y400  = 9'd300;
    localparam logic [Y400_W-1:0]  LAST_Y400  = 9'd399;
    localparam logic [ACC_W-1:0]   QUAD_CENT  = 17'd400;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] FIRST_DAY = 5'd1;

    // shared adder operations
    typedef enum logic [2:0] {
        ALU_MOD,
        ALU_FWD,
        ALU_BWD,
        ALU_NEXT,
        ALU_PREV
    } t_alu_op;

    // leap year from the year modulo 400
    function automatic logic is_leap(input logic [Y400_W-1:0] y400);
        logic century;
        century = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
        return (y400[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> hdl/gdas_if.sv
interface gdas_in_if;
    import gdas_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [DAY_W-1:0]          day;
    logic [MONTH_W-1:0]        month;
    logic [YEAR_W-1:0]         year;
    logic signed [COUNT_W-1:0] day_count;

    modport source (output valid, func, day, month, year, day_count, input ready);
    modport sink   (input valid, func, day, month, year, day_count, output ready);
endinterface

interface gdas_out_if;
    import gdas_pkg::*;

    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;
    logic               was_reset;

    modport source (output valid, out_day, out_month, out_year, was_reset, input ready);
    modport sink   (input valid, out_day, out_month, out_year, was_reset, output ready);
endinterface

>>> hdl/gdas_alu.sv
module gdas_alu (
    input  gdas_pkg::t_alu_op                    i_op,
    input  logic signed [gdas_pkg::ACC_W-1:0]    i_acc,
    input  logic [gdas_pkg::YEAR_W-1:0]          i_ymod,
    input  logic signed [gdas_pkg::COUNT_W-1:0]  i_cnt,
    input  logic [gdas_pkg::DAY_W-1:0]           i_len,
    output logic signed [gdas_pkg::ACC_W-1:0]    o_sum,
    output logic                                 o_pos,
    output logic                                 o_neg
);
    import gdas_pkg::*;

    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] cnt_x;
    logic signed [ACC_W-1:0] len_x;

    assign cnt_x = ACC_W'(i_cnt);
    assign len_x = signed'({{(ACC_W-DAY_W){1'b0}}, i_len});

    // operand select for the single adder
    always_comb begin
        a = i_acc;
        b = len_x;
        unique case (i_op)
            ALU_MOD: begin
                a = signed'({{(ACC_W-YEAR_W){1'b0}}, i_ymod});
                b = -signed'(QUAD_CENT);
            end
            ALU_FWD:  b = cnt_x;
            ALU_BWD:  b = -cnt_x;
            ALU_NEXT: b = -len_x;
            ALU_PREV: b = len_x;
            default:  b = len_x;
        endcase
    end

    assign o_sum = a + b;
    assign o_neg = o_sum[ACC_W-1];
    assign o_pos = !o_neg && (o_sum != '0);

endmodule

>>> hdl/gregorian_date_add_sub_days.sv
// Gregorian date plus or minus a day count.
// i_in carries one request beat: func (0 add, 1 subtract), a start date
// (day, month, year) and a signed day_count. o_out carries one result beat:
// the moved date and was_reset, set when the start date was invalid (the
// date 01/01/1900 is used instead) or a subtraction ran below 01/01/1900
// (the result is then that date). A count of zero or less returns the date.
// One request is handled at a time; i_in.ready is high only while idle.
// The year modulo 400 is first found by repeated subtraction of 400;
// for a count above zero the count is then walked one month per cycle
// (at most about 1080 months for a full count), all on one shared adder.
// The next request can be taken in the same cycle the result appears.
// A finished result sits in the output register; the next request is taken
// while it waits, and a second result waits in the sequencer until the
// receiver takes the first, so a stalled receiver loses nothing.
// Reset (synchronous, active low) returns to idle with no result pending.
module gregorian_date_add_sub_days (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gdas_in_if.sink     i_in,
    gdas_out_if.source  o_out
);
    import gdas_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_LOAD,
        S_WALK_ADD,
        S_WALK_SUB,
        S_DONE
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_func, n_func;
    logic signed [COUNT_W-1:0] r_cnt, n_cnt;
    logic signed [ACC_W-1:0]   r_d, n_d;
    logic [MONTH_W-1:0]        r_m, n_m;
    logic [YEAR_W-1:0]         r_y, n_y;
    logic [YEAR_W-1:0]         r_ymod, n_ymod;
    logic [Y400_W-1:0]         r_y400, n_y400;
    logic                      r_flag, n_flag;
    logic                      r_out_valid, n_out_valid;
    logic [DAY_W-1:0]          r_out_day, n_out_day;
    logic [MONTH_W-1:0]        r_out_month, n_out_month;
    logic [YEAR_W-1:0]         r_out_year, n_out_year;
    logic                      r_out_flag, n_out_flag;

    t_alu_op                 alu_op;
    logic [DAY_W-1:0]        alu_len;
    logic signed [ACC_W-1:0] alu_sum;
    logic                    alu_pos;
    logic                    alu_neg;

    logic               in_beat;
    logic               out_free;
    logic [DAY_W-1:0]   len_cur;
    logic [DAY_W-1:0]   len_prev;
    logic [MONTH_W-1:0] m_prev;
    logic [YEAR_W-1:0]  y_prev;
    logic [Y400_W-1:0]  y400_prev;
    logic [MONTH_W-1:0] m_next;
    logic [YEAR_W-1:0]  y_next;
    logic [Y400_W-1:0]  y400_next;
    logic [DAY_W-1:0]   len_check;
    logic               date_ok;

    assign in_beat  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // month neighbors with year rollover
    always_comb begin
        if (r_m == MON_DEC) begin
            m_next    = MON_JAN;
            y_next    = r_y + 1'b1;
            y400_next = (r_y400 == LAST_Y400) ? '0 : r_y400 + 1'b1;
        end else begin
            m_next    = r_m + 1'b1;
            y_next    = r_y;
            y400_next = r_y400;
        end
        if (r_m == MON_JAN) begin
            m_prev    = MON_DEC;
            y_prev    = r_y - 1'b1;
            y400_prev = (r_y400 == '0) ? LAST_Y400 : r_y400 - 1'b1;
        end else begin
            m_prev    = r_m - 1'b1;
            y_prev    = r_y;
            y400_prev = r_y400;
        end
    end

    assign len_cur   = month_len(r_m, is_leap(r_y400));
    assign len_prev  = month_len(m_prev, is_leap(y400_prev));
    assign len_check = month_len(r_m, is_leap(r_ymod[Y400_W-1:0]));

    // start date check, year modulo 400 is settled in r_ymod
    assign date_ok = (r_d != '0) && (r_m >= MON_JAN) && (r_m <= MON_DEC) &&
                     (r_y >= BASE_YEAR) &&
                     (r_d <= signed'({{(ACC_W-DAY_W){1'b0}}, len_check}));

    // adder operation per step
    always_comb begin
        alu_op  = ALU_NEXT;
        alu_len = len_cur;
        unique case (r_state)
            S_MOD:      alu_op = ALU_MOD;
            S_LOAD:     alu_op = r_func ? ALU_BWD : ALU_FWD;
            S_WALK_SUB: begin
                alu_op  = ALU_PREV;
                alu_len = len_prev;
            end
            default:    alu_op = ALU_NEXT;
        endcase
    end

    gdas_alu u_alu (
        .i_op   (alu_op),
        .i_acc  (r_d),
        .i_ymod (r_ymod),
        .i_cnt  (r_cnt),
        .i_len  (alu_len),
        .o_sum  (alu_sum),
        .o_pos  (alu_pos),
        .o_neg  (alu_neg)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_cnt       = r_cnt;
        n_d         = r_d;
        n_m         = r_m;
        n_y         = r_y;
        n_ymod      = r_ymod;
        n_y400      = r_y400;
        n_flag      = r_flag;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_day   = r_out_day;
        n_out_month = r_out_month;
        n_out_year  = r_out_year;
        n_out_flag  = r_out_flag;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_func  = i_in.func;
                    n_cnt   = i_in.day_count;
                    n_d     = signed'({{(ACC_W-DAY_W){1'b0}}, i_in.day});
                    n_m     = i_in.month;
                    n_y     = i_in.year;
                    n_ymod  = i_in.year;
                    n_flag  = 1'b0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (!alu_neg) begin
                    n_ymod = alu_sum[YEAR_W-1:0];
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_y400 = r_ymod[Y400_W-1:0];
                if (!date_ok) begin
                    n_d    = signed'({{(ACC_W-DAY_W){1'b0}}, FIRST_DAY});
                    n_m    = MON_JAN;
                    n_y    = BASE_YEAR;
                    n_y400 = BASE_Y400;
                    n_flag = 1'b1;
                end
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (r_cnt[COUNT_W-1] || (r_cnt == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_d     = alu_sum;
                    n_state = r_func ? S_WALK_SUB : S_WALK_ADD;
                end
            end
            S_WALK_ADD: begin
                if (alu_pos) begin
                    n_d    = alu_sum;
                    n_m    = m_next;
                    n_y    = y_next;
                    n_y400 = y400_next;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK_SUB: begin
                if (!r_d[ACC_W-1] && (r_d != '0)) begin
                    n_state = S_DONE;
                end else if (y_prev < BASE_YEAR) begin
                    // ran below the first supported date
                    n_d     = signed'({{(ACC_W-DAY_W){1'b0}}, FIRST_DAY});
                    n_m     = MON_JAN;
                    n_y     = BASE_YEAR;
                    n_flag  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_d    = alu_sum;
                    n_m    = m_prev;
                    n_y    = y_prev;
                    n_y400 = y400_prev;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_day   = r_d[DAY_W-1:0];
                    n_out_month = r_m;
                    n_out_year  = r_y;
                    n_out_flag  = r_flag;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_func      <= n_func;
        r_cnt       <= n_cnt;
        r_d         <= n_d;
        r_m         <= n_m;
        r_y         <= n_y;
        r_ymod      <= n_ymod;
        r_y400      <= n_y400;
        r_flag      <= n_flag;
        r_out_day   <= n_out_day;
        r_out_month <= n_out_month;
        r_out_year  <= n_out_year;
        r_out_flag  <= n_out_flag;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.out_day   = r_out_day;
    assign o_out.out_month = r_out_month;
    assign o_out.out_year  = r_out_year;
    assign o_out.was_reset = r_out_flag;

endmodule

>>> hdl/gdas_chk.sv
module gdas_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [gdas_pkg::DAY_W-1:0]    i_out_day,
    input logic [gdas_pkg::MONTH_W-1:0]  i_out_month,
    input logic [gdas_pkg::YEAR_W-1:0]   i_out_year,
    input logic                          i_out_flag
);
    import gdas_pkg::*;

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_day) && $stable(i_out_month) &&
            $stable(i_out_year) && $stable(i_out_flag))
        else $error("result payload changed while stalled");

    // block is busy right after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    // every result has a day of at least 1 and a month from 1 to 12
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_day >= FIRST_DAY) && (i_out_month >= MON_JAN) &&
                        (i_out_month <= MON_DEC))
        else $error("result date out of range");

endmodule

bind gregorian_date_add_sub_days gdas_chk u_gdas_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_day   (o_out.out_day),
    .i_out_month (o_out.out_month),
    .i_out_year  (o_out.out_year),
    .i_out_flag  (o_out.was_reset)
);

>>> dv/tb.sv
module tb;
    import gdas_pkg::*;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    // whether a directed row carries a hand-written result
    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    localparam int N_DIRECTED   = 25;
    localparam int N_PER_PHASE  = 135;
    localparam int N_PHASES     = 4;
    // longest walk: full count of months plus the year reduction, with margin
    localparam int DRAIN_CYCLES = 1200;
    localparam int MAX_PRINTS   = 30;

    typedef struct packed {
        logic                      func;
        logic [DAY_W-1:0]          day;
        logic [MONTH_W-1:0]        month;
        logic [YEAR_W-1:0]         year;
        logic signed [COUNT_W-1:0] count;
    } t_date_req;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               flag;
    } t_date_res;

    typedef struct packed {
        logic                      func;
        logic [DAY_W-1:0]          day;
        logic [MONTH_W-1:0]        month;
        logic [YEAR_W-1:0]         year;
        logic signed [COUNT_W-1:0] count;
        logic                      typed;
        logic [DAY_W-1:0]          e_day;
        logic [MONTH_W-1:0]        e_month;
        logic [YEAR_W-1:0]         e_year;
        logic                      e_flag;
    } t_dir_row;

    // func, day, month, year, count, typed?, expected day, month, year, flag
    localparam t_dir_row DIR_ROWS [N_DIRECTED] = '{
        // zero or negative count passes the date through
        '{OP_ADD,  1,  1,  1900,      0, TYPED,  1,  1, 1900, 0},
        '{OP_ADD, 15,  6,  2023, -32768, TYPED, 15,  6, 2023, 0},
        '{OP_SUB, 15,  6,  2023,     -1, TYPED, 15,  6, 2023, 0},
        '{OP_ADD, 29,  2,  2000,      0, TYPED, 29,  2, 2000, 0},
        // invalid start dates fall back to the default
        '{OP_ADD,  0,  5,  2000,      0, TYPED,  1,  1, 1900, 1},
        '{OP_ADD, 31,  4,  2001,      0, TYPED,  1,  1, 1900, 1},
        '{OP_SUB, 10,  0,  2000,      0, TYPED,  1,  1, 1900, 1},
        '{OP_ADD, 31, 15, 16383,      0, TYPED,  1,  1, 1900, 1},
        '{OP_ADD, 29,  2,  1900,      0, TYPED,  1,  1, 1900, 1},
        '{OP_ADD,  1,  1,  1899,      1, TYPED,  2,  1, 1900, 1},
        '{OP_SUB, 31, 13,  2000,      5, TYPED,  1,  1, 1900, 1},
        // subtraction below the base date
        '{OP_SUB,  1,  1,  1900,      1, TYPED,  1,  1, 1900, 1},
        '{OP_SUB, 15,  7,  1950,  32767, TYPED,  1,  1, 1900, 1},
        // month, year and leap february edges
        '{OP_ADD, 31, 12,  1999,      1, TYPED,  1,  1, 2000, 0},
        '{OP_ADD, 28,  2,  2000,      1, TYPED, 29,  2, 2000, 0},
        '{OP_ADD, 28,  2,  1900,      1, TYPED,  1,  3, 1900, 0},
        '{OP_SUB,  1,  3,  2024,      1, TYPED, 29,  2, 2024, 0},
        '{OP_SUB,  1,  3,  2100,      1, TYPED, 28,  2, 2100, 0},
        '{OP_SUB,  1,  1,  2000,      1, TYPED, 31, 12, 1999, 0},
        '{OP_ADD, 30,  1,  2023,     30, TYPED,  1,  3, 2023, 0},
        '{OP_ADD,  1,  1,  2000,    366, TYPED,  1,  1, 2001, 0},
        '{OP_SUB,  1,  1, 16383,      1, TYPED, 31, 12, 16382, 0},
        // full counts, including the year wrap at the top
        '{OP_ADD,  1,  1,  1900,  32767, PRED,   0,  0,    0, 0},
        '{OP_SUB, 31, 12,  9999,  32767, PRED,   0,  0,    0, 0},
        '{OP_ADD, 31, 12, 16383,  32767, PRED,   0,  0,    0, 0}
    };

    logic i_clk;
    logic i_rst_n;

    gdas_in_if  req_if ();
    gdas_out_if res_if ();

    gregorian_date_add_sub_days uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    t_date_res expected_dates [$];
    int        req_idle_pct;
    int        res_stall_pct;
    int        n_sent;
    int        n_checked;
    int        n_flagged;
    int        n_errors;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // date arithmetic used for prediction
    function automatic bit is_leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in_month(input int m, input int y);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return is_leap_year(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic t_date_res shift_date(input t_date_req r);
        int        d;
        int        m;
        int        y;
        int        n;
        logic      flag;
        t_date_res res;
        d    = int'(r.day);
        m    = int'(r.month);
        y    = int'(r.year);
        n    = int'(r.count);
        flag = 1'b0;
        // invalid start date is replaced by the base date
        if (d < 1 || m < 1 || m > 12 || y < int'(BASE_YEAR) || d > days_in_month(m, y)) begin
            d    = 1;
            m    = 1;
            y    = int'(BASE_YEAR);
            flag = 1'b1;
        end
        if (n > 0) begin
            if (r.func == OP_ADD) begin
                d += n;
                while (d > days_in_month(m, y)) begin
                    d -= days_in_month(m, y);
                    m++;
                    if (m > 12) begin
                        m = 1;
                        y++;
                    end
                end
            end else begin
                d -= n;
                while (d < 1 && y >= int'(BASE_YEAR)) begin
                    m--;
                    if (m < 1) begin
                        m = 12;
                        y--;
                    end
                    if (y >= int'(BASE_YEAR))
                        d += days_in_month(m, y);
                end
                // walked below the base date
                if (y < int'(BASE_YEAR)) begin
                    d    = 1;
                    m    = 1;
                    y    = int'(BASE_YEAR);
                    flag = 1'b1;
                end
            end
        end
        res.day   = DAY_W'(d);
        res.month = MONTH_W'(m);
        res.year  = YEAR_W'(y);
        res.flag  = flag;
        return res;
    endfunction

    // random request generation
    function automatic t_date_req valid_date(input int y_lo, input int y_hi);
        t_date_req r;
        r.func  = 1'($urandom_range(1, 0));
        r.year  = YEAR_W'($urandom_range(y_hi, y_lo));
        r.month = MONTH_W'($urandom_range(12, 1));
        r.day   = DAY_W'($urandom_range(days_in_month(r.month, r.year), 1));
        r.count = '0;
        return r;
    endfunction

    function automatic t_date_req rand_req();
        t_date_req r;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            // ordinary dates, mostly short moves
            r = ($urandom_range(99) < 85) ? valid_date(1900, 2500) : valid_date(1900, 16383);
            r.count = ($urandom_range(99) < 70) ? COUNT_W'($urandom_range(400, 1))
                                                : COUNT_W'($urandom_range(4000, 1));
        end else if (pick < 70) begin
            // near the base year, going back: underflow is common
            r = valid_date(1900, 1915);
            r.func  = OP_SUB;
            r.count = COUNT_W'($urandom_range(8000, 1));
        end else if (pick < 78) begin
            // zero or negative count
            r = valid_date(1900, 16383);
            r.count = COUNT_W'(-int'($urandom_range(32768, 0)));
        end else if (pick < 88) begin
            // raw fields, many invalid dates
            r.func  = 1'($urandom_range(1, 0));
            r.day   = DAY_W'($urandom_range(31, 0));
            r.month = MONTH_W'($urandom_range(15, 0));
            r.year  = YEAR_W'($urandom_range(16383, 0));
            r.count = COUNT_W'($urandom_range(65535, 65036)) ^ COUNT_W'($urandom_range(1, 0) << 15);
        end else if (pick < 94) begin
            // month ends and february, one step across
            r = valid_date(1896, 2404);
            r.month = ($urandom_range(1, 0) == 1) ? MON_FEB : MONTH_W'($urandom_range(12, 1));
            r.day   = DAY_W'(days_in_month(r.month, r.year) - $urandom_range(1, 0));
            if (r.func == OP_SUB)
                r.day = DAY_W'($urandom_range(2, 1));
            r.count = COUNT_W'($urandom_range(3, 1));
        end else begin
            // long walks anywhere in the year range
            r = valid_date(1900, 16383);
            r.count = COUNT_W'($urandom_range(32767, 20000));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < MAX_PRINTS)
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
        n_errors++;
    endtask

    // request driver: one beat, with random idle cycles ahead of it
    task automatic send_req(input t_date_req r, input t_date_res want);
        while ($urandom_range(99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= r.func;
        req_if.day       <= r.day;
        req_if.month     <= r.month;
        req_if.year      <= r.year;
        req_if.day_count <= r.count;
        do @(posedge i_clk); while (!req_if.ready);
        expected_dates.push_back(want);
        n_sent++;
        @(negedge i_clk);
    endtask

    // result receiver back-pressure
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= res_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin : chk_result
        t_date_res got;
        t_date_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.out_day, res_if.out_month, res_if.out_year, res_if.was_reset};
            if (expected_dates.size() == 0) begin
                report_mismatch("unexpected result beat, day", got.day, 0);
            end else begin
                want = expected_dates.pop_front();
                if (got.day != want.day)
                    report_mismatch("day", got.day, want.day);
                if (got.month != want.month)
                    report_mismatch("month", got.month, want.month);
                if (got.year != want.year)
                    report_mismatch("year", got.year, want.year);
                if (got.flag != want.flag)
                    report_mismatch("was_reset", got.flag, want.flag);
                n_checked++;
                if (got.flag)
                    n_flagged++;
            end
        end
    end

    // stimulus
    initial begin : stim
        t_date_req r;
        t_date_res want;
        t_dir_row  row;
        int        idle_pct [N_PHASES];
        int        stall_pct [N_PHASES];
        idle_pct  = '{0, 85, 0, 16};
        stall_pct = '{0, 0, 85, 16};
        req_idle_pct     = 0;
        res_stall_pct    = 0;
        n_sent           = 0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.func      = OP_ADD;
        req_if.day       = '0;
        req_if.month     = '0;
        req_if.year      = '0;
        req_if.day_count = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIR_ROWS[i];
            r   = '{row.func, row.day, row.month, row.year, row.count};
            if (row.typed)
                want = '{row.e_day, row.e_month, row.e_year, row.e_flag};
            else
                want = shift_date(r);
            send_req(r, want);
        end

        // random requests over the idle and stall phases
        for (int p = 0; p < N_PHASES; p++) begin
            req_idle_pct  = idle_pct[p];
            res_stall_pct = stall_pct[p];
            for (int k = 0; k < N_PER_PHASE; k++) begin
                r = rand_req();
                send_req(r, shift_date(r));
            end
        end
        req_if.valid <= 1'b0;

        // drain, then watch for stray beats
        while (expected_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d date requests sent (%0d from the table), %0d results checked, %0d flagged",
                 n_sent, N_DIRECTED, n_checked, n_flagged);
        $display("ran with no gaps, sender gaps, receiver stalls and both; %0d mismatches",
                 n_errors);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("watchdog expired with %0d results outstanding", expected_dates.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
